### rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every rising edge outside reset.
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression must never be true at a rising edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_AT(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

### rtl/core/rme_pkg.sv
// ---------------------------------------------------------------------------
// Range median/EMA filter package
// Shared widths, reset values, register indexes and the step control struct.
// ---------------------------------------------------------------------------
`default_nettype none

package rme_pkg;

    localparam int DIST_W     = 16;
    localparam int OUT_W      = 21;
    localparam int CH_FIELD_W = 2;
    localparam int CH_CMP_W   = 4;
    localparam int CH_SEL_W   = 3;
    localparam int OFFSET_W   = 8;
    localparam int MASK_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int CALC_W     = 32;

    localparam int WINDOW_TAPS_DEF   = 3;
    localparam int CHANNEL_COUNT_DEF = 3;
    localparam int FRACTION_BITS_DEF = 4;

    localparam logic [DIST_W-1:0]   RESET_MM     = 16'd2000;
    localparam logic [DIST_W-1:0]   INVALID_HIGH = 16'hFFFF;
    localparam logic [OFFSET_W-1:0] LEFT_OFFSET_RST  = 8'd0;
    localparam logic [OFFSET_W-1:0] FRONT_OFFSET_RST = 8'd30;
    localparam logic [OFFSET_W-1:0] RIGHT_OFFSET_RST = 8'd10;
    localparam logic [MASK_W-1:0]   CLAMP_MASK_RST   = 3'b010;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEFT_OFFSET  = 3'd0,
        CFG_FRONT_OFFSET = 3'd1,
        CFG_RIGHT_OFFSET = 3'd2,
        CFG_CLAMP_MASK   = 3'd3
    } cfg_reg_t;

    typedef enum logic [CH_FIELD_W-1:0] {
        CH_LEFT  = 2'd0,
        CH_FRONT = 2'd1,
        CH_RIGHT = 2'd2
    } chan_name_t;

    // Control for one filter step, handed from the top level to the state.
    typedef struct packed {
        logic                advance;
        logic                in_range;
        logic                rejected;
        logic [CH_SEL_W-1:0] chan;
    } rme_step_t;

endpackage

`default_nettype wire

### rtl/core/rme_median.sv
// ---------------------------------------------------------------------------
// Median select
// Picks the middle value of a small window by ranking every tap in parallel.
// ---------------------------------------------------------------------------
`default_nettype none

module rme_median #(
    parameter int TAPS = rme_pkg::WINDOW_TAPS_DEF
) (
    input  wire logic [TAPS-1:0][rme_pkg::DIST_W-1:0] taps,
    output logic      [rme_pkg::DIST_W-1:0]           median
);
    import rme_pkg::*;

    localparam int RANK_W = $clog2(TAPS);
    localparam logic [RANK_W-1:0] MID_RANK = RANK_W'(TAPS / 2);

    logic [TAPS-1:0][RANK_W-1:0] rank;

    // Ties are broken by tap position, so every tap gets a distinct rank.
    always_comb begin
        rank = '0;
        for (int i = 0; i < TAPS; i++) begin
            for (int j = 0; j < TAPS; j++) begin
                if (j != i) begin
                    rank[i] = rank[i] + RANK_W'((taps[j] < taps[i]) ||
                                                ((taps[j] == taps[i]) && (j < i)));
                end
            end
        end
    end

    always_comb begin
        median = '0;
        for (int i = 0; i < TAPS; i++) begin
            if (rank[i] == MID_RANK) begin
                median = taps[i];
            end
        end
    end

endmodule

`default_nettype wire

### rtl/core/rme_chan_state.sv
// ---------------------------------------------------------------------------
// Channel state
// Per-channel held reading, median history and running average with update.
// ---------------------------------------------------------------------------
`default_nettype none

module rme_chan_state #(
    parameter int CHANNEL_COUNT = rme_pkg::CHANNEL_COUNT_DEF,
    parameter int WINDOW_TAPS   = rme_pkg::WINDOW_TAPS_DEF,
    parameter int FRACTION_BITS = rme_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                                      aclk,
    input  wire logic                                      aresetn,
    input  wire rme_pkg::rme_step_t                        step,
    input  wire logic [rme_pkg::DIST_W-1:0]                raw_mm,
    output logic      [rme_pkg::DIST_W-1:0]                held_new,
    output logic      [rme_pkg::DIST_W+FRACTION_BITS-1:0]  avg_new
);
    import rme_pkg::*;

    localparam int AVG_W    = DIST_W + FRACTION_BITS;
    localparam int HIST_LEN = WINDOW_TAPS - 1;
    localparam int CH_IDX_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
    localparam logic [AVG_W-1:0] AVG_RST = AVG_W'(RESET_MM) << FRACTION_BITS;

    logic [DIST_W-1:0] held_reg [CHANNEL_COUNT];
    logic [HIST_LEN-1:0][DIST_W-1:0] hist_reg [CHANNEL_COUNT];
    logic [AVG_W-1:0]  avg_reg  [CHANNEL_COUNT];

    logic [CH_IDX_W-1:0]                 sel;
    logic [WINDOW_TAPS-1:0][DIST_W-1:0]  taps;
    logic [DIST_W-1:0]                   median;
    logic [AVG_W:0]                      avg_sum;

    // Out-of-range channels read entry zero; the top level discards the result.
    assign sel      = step.in_range ? step.chan[CH_IDX_W-1:0] : '0;
    assign held_new = step.rejected ? held_reg[sel] : raw_mm;

    always_comb begin
        taps[0] = held_new;
        for (int k = 0; k < HIST_LEN; k++) begin
            taps[k+1] = hist_reg[sel][k];
        end
    end

    rme_median #(
        .TAPS(WINDOW_TAPS)
    ) u_median (
        .taps  (taps),
        .median(median)
    );

    assign avg_sum = (AVG_W+1)'(avg_reg[sel]) + ((AVG_W+1)'(median) << FRACTION_BITS);
    assign avg_new = avg_sum[AVG_W:1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < CHANNEL_COUNT; c++) begin
                held_reg[c] <= RESET_MM;
                avg_reg[c]  <= AVG_RST;
                for (int k = 0; k < HIST_LEN; k++) begin
                    hist_reg[c][k] <= RESET_MM;
                end
            end
        end else if (step.advance && step.in_range) begin
            held_reg[sel]    <= held_new;
            avg_reg[sel]     <= avg_new;
            hist_reg[sel][0] <= held_new;
            for (int k = 1; k < HIST_LEN; k++) begin
                hist_reg[sel][k] <= hist_reg[sel][k-1];
            end
        end
    end

endmodule

`default_nettype wire

### rtl/core/range_median_ema_filter_core.sv
// ---------------------------------------------------------------------------
// Range median/EMA filter core
// Conditions range readings: rejection, 3-tap median, alpha-1/2 average,
// per-channel offset and optional clamp at zero.
// ---------------------------------------------------------------------------
//
//   Channel   Prefix   Direction   Carries
//   input     s_       in          channel, raw distance, timeout flag
//   result    m_       out         filtered distance, held reading, reject flag
//   config    cfg_     in          register index and write data
//
// One request is accepted per clock while the output is not stalled; a request
// passes the input register, then the result register, before reaching m_valid.
// The channel state is read and written in the same cycle the result is
// registered, so consecutive requests for one channel need no spacing.
// When the result register is full and m_ready is low, the input register
// holds and s_ready drops once it is occupied as well.
// Synchronous active-low reset restores all channel state, the configuration
// registers and the valid flags to their defaults; no clearing pass follows.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module range_median_ema_filter_core #(
    parameter int CHANNEL_COUNT = rme_pkg::CHANNEL_COUNT_DEF,
    parameter int WINDOW_TAPS   = rme_pkg::WINDOW_TAPS_DEF,
    parameter int FRACTION_BITS = rme_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,

    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [rme_pkg::CH_FIELD_W-1:0]     s_channel,
    input  wire logic [rme_pkg::DIST_W-1:0]         s_raw_distance_mm,
    input  wire logic                               s_timed_out,

    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic signed [rme_pkg::OUT_W-1:0]        m_filtered_distance,
    output logic      [rme_pkg::DIST_W-1:0]         m_last_valid_mm,
    output logic                                    m_reading_rejected,

    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [rme_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [rme_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import rme_pkg::*;

    localparam int AVG_W = DIST_W + FRACTION_BITS;

    // Configuration registers.
    logic [OFFSET_W-1:0] left_offset_reg;
    logic [OFFSET_W-1:0] front_offset_reg;
    logic [OFFSET_W-1:0] right_offset_reg;
    logic [MASK_W-1:0]   clamp_mask_reg;

    // Input register.
    logic                  in_valid_reg;
    logic [CH_FIELD_W-1:0] in_channel_reg;
    logic [DIST_W-1:0]     in_raw_reg;
    logic                  in_timed_out_reg;

    // Result register.
    logic                  out_valid_reg;
    logic [OUT_W-1:0]      out_filtered_reg;
    logic [DIST_W-1:0]     out_last_valid_reg;
    logic                  out_rejected_reg;

    logic                  advance;
    logic [CH_CMP_W-1:0]   ch_ext;
    logic                  in_range;
    logic                  rejected;
    rme_step_t             step;
    logic [DIST_W-1:0]     held_new;
    logic [AVG_W-1:0]      avg_new;
    logic [OFFSET_W-1:0]   offset_sel;
    logic                  clamp_en;
    logic signed [CALC_W-1:0] diff;
    logic [OUT_W-1:0]      out_filtered_next;
    logic [DIST_W-1:0]     out_last_valid_next;

    // The held item moves to the result register whenever that register is
    // empty or being drained this cycle.
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_offset_reg  <= LEFT_OFFSET_RST;
            front_offset_reg <= FRONT_OFFSET_RST;
            right_offset_reg <= RIGHT_OFFSET_RST;
            clamp_mask_reg   <= CLAMP_MASK_RST;
        end else if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_LEFT_OFFSET:  left_offset_reg  <= cfg_data;
                CFG_FRONT_OFFSET: front_offset_reg <= cfg_data;
                CFG_RIGHT_OFFSET: right_offset_reg <= cfg_data;
                CFG_CLAMP_MASK:   clamp_mask_reg   <= cfg_data[MASK_W-1:0];
                default: begin
                    // Indexes past the register list are ignored.
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_channel_reg   <= s_channel;
            in_raw_reg       <= s_raw_distance_mm;
            in_timed_out_reg <= s_timed_out;
        end
    end

    // A reading is rejected on timeout or on either out-of-band code.
    assign ch_ext   = CH_CMP_W'(in_channel_reg);
    assign in_range = ch_ext < CH_CMP_W'(CHANNEL_COUNT);
    assign rejected = in_timed_out_reg || (in_raw_reg == '0) || (in_raw_reg == INVALID_HIGH);

    always_comb begin
        step.advance  = advance;
        step.in_range = in_range;
        step.rejected = rejected;
        step.chan     = ch_ext[CH_SEL_W-1:0];
    end

    rme_chan_state #(
        .CHANNEL_COUNT(CHANNEL_COUNT),
        .WINDOW_TAPS  (WINDOW_TAPS),
        .FRACTION_BITS(FRACTION_BITS)
    ) u_chan_state (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .raw_mm  (in_raw_reg),
        .held_new(held_new),
        .avg_new (avg_new)
    );

    // Only the three named channels have an offset and a clamp bit.
    always_comb begin
        unique case (chan_name_t'(in_channel_reg))
            CH_LEFT: begin
                offset_sel = left_offset_reg;
                clamp_en   = clamp_mask_reg[0];
            end
            CH_FRONT: begin
                offset_sel = front_offset_reg;
                clamp_en   = clamp_mask_reg[1];
            end
            CH_RIGHT: begin
                offset_sel = right_offset_reg;
                clamp_en   = clamp_mask_reg[2];
            end
            default: begin
                offset_sel = '0;
                clamp_en   = 1'b0;
            end
        endcase
    end

    assign diff = $signed(CALC_W'(avg_new)) -
                  $signed(CALC_W'(offset_sel) << FRACTION_BITS);

    always_comb begin
        if (!in_range) begin
            out_filtered_next   = '0;
            out_last_valid_next = '0;
        end else if (clamp_en && (diff < 0)) begin
            out_filtered_next   = '0;
            out_last_valid_next = held_new;
        end else begin
            out_filtered_next   = diff[OUT_W-1:0];
            out_last_valid_next = held_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_filtered_reg   <= out_filtered_next;
            out_last_valid_reg <= out_last_valid_next;
            out_rejected_reg   <= rejected || !in_range;
        end
    end

    assign m_valid             = out_valid_reg;
    assign m_filtered_distance = $signed(out_filtered_reg);
    assign m_last_valid_mm     = out_last_valid_reg;
    assign m_reading_rejected  = out_rejected_reg;

    // An accepted reading always leaves a valid, in-band held value.
    `ASSERT_AT(a_held_in_band, aclk, aresetn, (out_valid_reg && !out_rejected_reg) |-> ((out_last_valid_reg != '0) && (out_last_valid_reg != INVALID_HIGH)), "accepted reading produced out-of-band held value")

    // Back-pressure reaches the input only when both registers are full.
    `ASSERT_AT(a_ready_only_when_full, aclk, aresetn, !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready), "input stalled without a full pipeline")

    // A held request with an empty result register reaches it in the next cycle.
    `ASSERT_AT(a_advance_fills_output, aclk, aresetn, (in_valid_reg && !out_valid_reg) |=> out_valid_reg, "held request did not reach the result register")

    // Clamped channels never present a negative distance.
    `ASSERT_NEVER(a_clamp_non_negative, aclk, aresetn, advance && in_range && clamp_en && out_filtered_next[OUT_W-1], "clamped channel produced negative output")

endmodule

`default_nettype wire
